// ===== src/sfq_pkg.sv =====
// ----------------------------------------------------------------------------
// sfq_pkg: shared types and codes for the searchable FIFO queue
// Operation and status codes, and the command bundle sent to every cell.
// ----------------------------------------------------------------------------
`default_nettype none

package sfq_pkg;

  localparam logic [2:0] OP_IDLE    = 3'd0;
  localparam logic [2:0] OP_ENQUEUE = 3'd1;
  localparam logic [2:0] OP_DEQUEUE = 3'd2;
  localparam logic [2:0] OP_CLEAR   = 3'd3;
  localparam logic [2:0] OP_SEARCH  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY_RD = 2'd1;
  localparam logic [1:0] ST_FULL_WR  = 2'd2;

  // Per-cycle command broadcast to the cell row.
  typedef struct packed {
    logic enq;      // tail cell loads the new value
    logic deq;      // every cell takes its rear neighbor's value
    logic capture;  // every cell latches its compare result
    logic scan;     // match flags move one cell toward the front
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== src/sfq_cell.sv =====
// ----------------------------------------------------------------------------
// sfq_cell: one queue slot
// Holds one entry and one match flag; shifts both toward the front.
// ----------------------------------------------------------------------------
`default_nettype none

module sfq_cell import sfq_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire cell_cmd_t             cmd,
  input  wire logic                  at_tail,
  input  wire logic                  in_range,
  input  wire logic [DATA_WIDTH-1:0] new_val,
  input  wire logic [DATA_WIDTH-1:0] nbr_val,
  input  wire logic                  nbr_match,
  output logic      [DATA_WIDTH-1:0] val,
  output logic                       match
);

  always_ff @(posedge clk) begin
    if (cmd.enq && at_tail) begin
      val <= new_val;
    end else if (cmd.deq) begin
      val <= nbr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      match <= in_range && (val == new_val);
    end else if (cmd.scan) begin
      match <= nbr_match;
    end
  end

endmodule

`default_nettype wire

// ===== src/searchable_fifo_queue_top.sv =====
// ----------------------------------------------------------------------------
// searchable_fifo_queue_top: FIFO queue with key search
// Shift-register queue built from a row of cells; front is cell 0.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one operation per beat:
//   idle, enqueue, dequeue, clear or search, with a value or search key.
//   Output channel (out_valid/out_ready) returns one result beat per input
//   beat: popped value, front and rear entries, count, flags, status.
// Flow:
//   Idle, enqueue, dequeue and clear finish in the accept cycle; the result
//   is registered and shown the next cycle, so one beat per cycle while
//   out_ready stays high. Search latches a compare flag in every cell,
//   then shifts the flags toward the front one cell per cycle until the
//   first set flag reaches cell 0, or on a miss until the flag of the
//   last entry has reached cell 0. in_ready stays low while the scan runs,
//   and the result is registered when it ends. An empty queue answers a
//   search at once; one item is in work at a time.
// Reset: count, rear register, scan state and out_valid clear; the cell
//   contents are left as they are (never read before written).
// Stall: in_ready drops while a search scans and while a result waits
//   without out_ready, so a stalled receiver holds the block.
// ----------------------------------------------------------------------------
`default_nettype none

module searchable_fifo_queue_top import sfq_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  operation,
  input  wire logic [31:0] value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [31:0] popped_value,
  output logic      [31:0] front_value,
  output logic      [31:0] rear_value,
  output logic      [4:0]  entry_count,
  output logic             search_hit,
  output logic      [3:0]  search_position,
  output logic             is_empty,
  output logic             is_full,
  output logic      [1:0]  status
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = $clog2(DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                  state, state_next;
  logic [CW-1:0]         count, count_next;
  logic [DATA_WIDTH-1:0] rear_val, rear_val_next;
  logic [PW-1:0]         scan_pos, scan_pos_next;

  logic                  accept;
  logic                  load_out;
  cell_cmd_t             cmd;
  logic [63:0]           val_wide;
  logic [DATA_WIDTH-1:0] val_in;

  logic [DATA_WIDTH-1:0] cell_val   [DEPTH];
  logic                  cell_match [DEPTH];

  // result being formed this cycle
  logic [DATA_WIDTH-1:0] res_popped, res_front;
  logic                  res_hit;
  logic [PW-1:0]         res_pos;
  logic [1:0]            res_status;

  assign val_wide = 64'(value);
  assign val_in   = val_wide[DATA_WIDTH-1:0];

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // cell row; the last cell sees an empty neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] nbr_val;
    logic                  nbr_match;
    if (i == DEPTH - 1) begin : g_last
      assign nbr_val   = '0;
      assign nbr_match = 1'b0;
    end else begin : g_mid
      assign nbr_val   = cell_val[i+1];
      assign nbr_match = cell_match[i+1];
    end
    sfq_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .at_tail  (count == CW'(i)),
      .in_range (CW'(i) < count),
      .new_val  (val_in),
      .nbr_val  (nbr_val),
      .nbr_match(nbr_match),
      .val      (cell_val[i]),
      .match    (cell_match[i])
    );
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    rear_val_next = rear_val;
    scan_pos_next = scan_pos;
    cmd           = '0;
    load_out      = 1'b0;
    res_popped    = '0;
    res_hit       = 1'b0;
    res_pos       = '0;
    res_status    = ST_OK;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          load_out = 1'b1;
          priority if (operation == OP_ENQUEUE) begin
            if (count == CW'(DEPTH)) begin
              res_status = ST_FULL_WR;
            end else begin
              cmd.enq       = 1'b1;
              count_next    = count + 1'b1;
              rear_val_next = val_in;
            end
          end else if (operation == OP_DEQUEUE) begin
            if (count == '0) begin
              res_status = ST_EMPTY_RD;
            end else begin
              cmd.deq    = 1'b1;
              res_popped = cell_val[0];
              count_next = count - 1'b1;
              if (count == CW'(1)) begin
                rear_val_next = '0;
              end
            end
          end else if (operation == OP_CLEAR) begin
            count_next    = '0;
            rear_val_next = '0;
          end else if (operation == OP_SEARCH) begin
            // empty queue: miss right away
            if (count != '0) begin
              cmd.capture   = 1'b1;
              load_out      = 1'b0;
              scan_pos_next = '0;
              state_next    = S_SCAN;
            end
          end else begin
            // idle and unused codes change nothing
          end
        end
      end
      S_SCAN: begin
        if (cell_match[0]) begin
          load_out   = 1'b1;
          res_hit    = 1'b1;
          res_pos    = scan_pos;
          state_next = S_IDLE;
        end else if ((CW'(scan_pos) + CW'(1)) >= count) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.scan      = 1'b1;
          scan_pos_next = scan_pos + 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase

    // front entry after the operation
    if (count_next == '0) begin
      res_front = '0;
    end else if (cmd.enq && (count == '0)) begin
      res_front = val_in;
    end else if (cmd.deq) begin
      res_front = cell_val[1];
    end else begin
      res_front = cell_val[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rear_val  <= '0;
      scan_pos  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      rear_val <= rear_val_next;
      scan_pos <= scan_pos_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register; payload needs no reset
  logic [63:0] popped_wide, front_wide, rear_wide;
  logic [15:0] count_wide, pos_wide;

  assign popped_wide = 64'(res_popped);
  assign front_wide  = 64'(res_front);
  assign rear_wide   = 64'(rear_val_next);
  assign count_wide  = 16'(count_next);
  assign pos_wide    = 16'(res_pos);

  always_ff @(posedge clk) begin
    if (load_out) begin
      popped_value    <= popped_wide[31:0];
      front_value     <= front_wide[31:0];
      rear_value      <= rear_wide[31:0];
      entry_count     <= count_wide[4:0];
      search_hit      <= res_hit;
      search_position <= pos_wide[3:0];
      is_empty        <= (count_next == '0);
      is_full         <= (count_next == CW'(DEPTH));
      status          <= res_status;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the searchable FIFO queue
// A directed table covers the empty and clear corners first. Random
// traffic follows, with fill, mixed and drain bursts, repeated under four
// handshake-pressure phases. A queue model predicts each result beat,
// or a hand-written result stands in, and each beat is checked field by field.
// ----------------------------------------------------------------------------
module tb;
  import sfq_pkg::*;

  localparam int DEPTH            = 16;
  localparam int RANDOM_PER_PHASE = 100;  // random beats per pressure phase
  localparam int BURST_LEN        = 35;   // beats per traffic burst
  localparam int MAX_GAP          = 24;   // longest sender idle run
  localparam int TAIL_CYCLES      = 24;   // longest search scan plus margin
  localparam int CYCLE_LIMIT      = 200000;

  // One result beat, in port order.
  typedef struct packed {
    logic [31:0] popped;
    logic [31:0] front;
    logic [31:0] rear;
    logic [4:0]  count;
    logic        hit;
    logic [3:0]  pos;
    logic        empty;
    logic        full;
    logic [1:0]  status;
  } queue_result_t;

  // One input beat; when fixed_res is set, res is the hand-written result.
  typedef struct packed {
    logic [2:0]    op;
    logic [31:0]   val;
    logic          fixed_res;
    queue_result_t res;
  } queue_beat_t;

  typedef enum int {MODE_FILL, MODE_MIXED, MODE_DRAIN} traffic_mode_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  operation;
  logic [31:0] value;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] popped_value;
  logic [31:0] front_value;
  logic [31:0] rear_value;
  logic [4:0]  entry_count;
  logic        search_hit;
  logic [3:0]  search_position;
  logic        is_empty;
  logic        is_full;
  logic [1:0]  status;

  // Queue model state: slots, front slot, next write slot, occupancy.
  // The 4-bit indices wrap at DEPTH on their own.
  logic [31:0] model_slots [DEPTH];
  logic [3:0]  model_front;
  logic [3:0]  model_rear;
  int          model_count;

  queue_result_t awaited_results[$];
  queue_beat_t   directed_beats[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int cycle_count    = 0;

  searchable_fifo_queue_top #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (32)
  ) uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .operation       (operation),
    .value           (value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .popped_value    (popped_value),
    .front_value     (front_value),
    .rear_value      (rear_value),
    .entry_count     (entry_count),
    .search_hit      (search_hit),
    .search_position (search_position),
    .is_empty        (is_empty),
    .is_full         (is_full),
    .status          (status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Queue model: applies one operation, returns the result beat it causes.
  // --------------------------------------------------------------------------
  function automatic queue_result_t apply_queue_op(input logic [2:0] op,
                                                   input logic [31:0] key);
    queue_result_t r;
    r = '0;
    case (op)
      OP_ENQUEUE: begin
        if (model_count >= DEPTH) begin
          r.status = ST_FULL_WR;
        end else begin
          model_slots[model_rear] = key;
          model_rear = model_rear + 4'd1;
          model_count++;
        end
      end
      OP_DEQUEUE: begin
        if (model_count == 0) begin
          r.status = ST_EMPTY_RD;
        end else begin
          r.popped = model_slots[model_front];
          model_front = model_front + 4'd1;
          model_count--;
        end
      end
      OP_CLEAR: begin
        // entries keep their contents, only the bookkeeping resets
        model_front = '0;
        model_rear  = '0;
        model_count = 0;
      end
      OP_SEARCH: begin
        // first match from the front wins
        for (int p = 0; p < model_count; p++) begin
          if (!r.hit && model_slots[4'(model_front + p)] == key) begin
            r.hit = 1'b1;
            r.pos = 4'(p);
          end
        end
      end
      default: ;  // idle and the unused codes change nothing
    endcase
    if (model_count != 0) begin
      r.front = model_slots[model_front];
      r.rear  = model_slots[4'(model_front + model_count - 1)];
    end
    r.count = 5'(model_count);
    r.empty = (model_count == 0);
    r.full  = (model_count == DEPTH);
    return r;
  endfunction

  // Hand-written result; the flags follow from the count.
  function automatic queue_result_t make_result(input logic [31:0] popped,
                                                input logic [31:0] front,
                                                input logic [31:0] rear,
                                                input int          count,
                                                input logic        hit,
                                                input logic [3:0]  pos,
                                                input logic [1:0]  st);
    queue_result_t r;
    r.popped = popped;
    r.front  = front;
    r.rear   = rear;
    r.count  = 5'(count);
    r.hit    = hit;
    r.pos    = pos;
    r.empty  = (count == 0);
    r.full   = (count == DEPTH);
    r.status = st;
    return r;
  endfunction

  function automatic queue_beat_t make_beat(input logic [2:0] op, input logic [31:0] val,
                                            input logic fixed_res, input queue_result_t res);
    queue_beat_t b;
    b.op        = op;
    b.val       = val;
    b.fixed_res = fixed_res;
    b.res       = res;
    return b;
  endfunction

  // --------------------------------------------------------------------------
  // Random traffic
  // --------------------------------------------------------------------------
  // Small pool values make duplicates, so first-match ordering gets exercised.
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 32'($urandom_range(0, 7));
    if (r < 40) return 32'h0000_0000;
    if (r < 45) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Search keys mostly come from what the queue holds right now.
  function automatic logic [31:0] pick_key();
    if (model_count > 0 && $urandom_range(0, 99) < 60)
      return model_slots[4'(model_front + $urandom_range(0, model_count - 1))];
    return pick_value();
  endfunction

  function automatic logic [2:0] pick_op(input traffic_mode_t mode);
    int r;
    int enq_cut;
    int deq_cut;
    int srch_cut;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:  begin enq_cut = 70; deq_cut = 80; srch_cut = 95; end
      MODE_DRAIN: begin enq_cut = 15; deq_cut = 80; srch_cut = 95; end
      default:    begin enq_cut = 35; deq_cut = 65; srch_cut = 90; end
    endcase
    if (r < enq_cut)  return OP_ENQUEUE;
    if (r < deq_cut)  return OP_DEQUEUE;
    if (r < srch_cut) return OP_SEARCH;
    // rare: clear, idle, or one of the unused codes above search
    case ($urandom_range(0, 4))
      0:       return OP_CLEAR;
      1:       return OP_IDLE;
      default: return 3'(OP_SEARCH + $urandom_range(1, 3));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender: optional idle gap, then hold valid until the beat is taken.
  // Valid is only lowered when a gap follows, so it never toggles in one step.
  // --------------------------------------------------------------------------
  task automatic send_beat(input queue_beat_t beat);
    int gap;
    queue_result_t predicted;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= beat.op;
    value     <= beat.val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // model stays in step even where the result is hand-written
    predicted = apply_queue_op(beat.op, beat.val);
    awaited_results.push_back(beat.fixed_res ? beat.res : predicted);
  endtask

  task automatic check_result(input queue_result_t want, input queue_result_t seen);
    if (want.popped !== seen.popped) begin
      $error("popped_value: expected %h, got %h", want.popped, seen.popped);
      error_count++;
    end
    if (want.front !== seen.front) begin
      $error("front_value: expected %h, got %h", want.front, seen.front);
      error_count++;
    end
    if (want.rear !== seen.rear) begin
      $error("rear_value: expected %h, got %h", want.rear, seen.rear);
      error_count++;
    end
    if (want.count !== seen.count) begin
      $error("entry_count: expected %0d, got %0d", want.count, seen.count);
      error_count++;
    end
    if (want.hit !== seen.hit) begin
      $error("search_hit: expected %b, got %b", want.hit, seen.hit);
      error_count++;
    end
    if (want.pos !== seen.pos) begin
      $error("search_position: expected %0d, got %0d", want.pos, seen.pos);
      error_count++;
    end
    if (want.empty !== seen.empty) begin
      $error("is_empty: expected %b, got %b", want.empty, seen.empty);
      error_count++;
    end
    if (want.full !== seen.full) begin
      $error("is_full: expected %b, got %b", want.full, seen.full);
      error_count++;
    end
    if (want.status !== seen.status) begin
      $error("status: expected %0d, got %0d", want.status, seen.status);
      error_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: check each taken result beat, then pick next cycle's ready.
  // Outputs are registered, so values read at the edge are pre-edge values.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    queue_result_t seen;
    queue_result_t want;
    if (!rst && out_valid && out_ready) begin
      seen.popped = popped_value;
      seen.front  = front_value;
      seen.rear   = rear_value;
      seen.count  = entry_count;
      seen.hit    = search_hit;
      seen.pos    = search_position;
      seen.empty  = is_empty;
      seen.full   = is_full;
      seen.status = status;
      if (awaited_results.size() == 0) begin
        $error("result beat with nothing outstanding");
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        check_result(want, seen);
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog: covers a hung handshake or a lost result.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    traffic_mode_t mode;
    logic [2:0]    op;
    logic [31:0]   val;

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    operation <= OP_IDLE;
    value     <= '0;
    model_front = '0;
    model_rear  = '0;
    model_count = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty corners, unused codes, search hits and misses,
    // duplicate keys, clear keeping stale entries, and draining to empty.
    directed_beats.push_back(make_beat(OP_IDLE, 32'h0, 1'b1,
      make_result(0, 0, 0, 0, 0, 0, ST_OK)));
    directed_beats.push_back(make_beat(OP_DEQUEUE, 32'h0, 1'b1,
      make_result(0, 0, 0, 0, 0, 0, ST_EMPTY_RD)));
    directed_beats.push_back(make_beat(OP_SEARCH, 32'h0, 1'b1,
      make_result(0, 0, 0, 0, 0, 0, ST_OK)));
    directed_beats.push_back(make_beat(3'(OP_SEARCH + 1), 32'hFFFF_FFFF, 1'b1,
      make_result(0, 0, 0, 0, 0, 0, ST_OK)));
    directed_beats.push_back(make_beat(3'(OP_SEARCH + 2), 32'hFFFF_FFFF, 1'b1,
      make_result(0, 0, 0, 0, 0, 0, ST_OK)));
    directed_beats.push_back(make_beat(3'(OP_SEARCH + 3), 32'hFFFF_FFFF, 1'b1,
      make_result(0, 0, 0, 0, 0, 0, ST_OK)));
    directed_beats.push_back(make_beat(OP_ENQUEUE, 32'h0, 1'b1,
      make_result(0, 0, 0, 1, 0, 0, ST_OK)));
    directed_beats.push_back(make_beat(OP_ENQUEUE, 32'hFFFF_FFFF, 1'b1,
      make_result(0, 0, 32'hFFFF_FFFF, 2, 0, 0, ST_OK)));
    directed_beats.push_back(make_beat(OP_SEARCH, 32'hFFFF_FFFF, 1'b1,
      make_result(0, 0, 32'hFFFF_FFFF, 2, 1, 1, ST_OK)));
    directed_beats.push_back(make_beat(OP_SEARCH, 32'h0, 1'b1,
      make_result(0, 0, 32'hFFFF_FFFF, 2, 1, 0, ST_OK)));
    directed_beats.push_back(make_beat(OP_SEARCH, 32'h1, 1'b1,
      make_result(0, 0, 32'hFFFF_FFFF, 2, 0, 0, ST_OK)));
    directed_beats.push_back(make_beat(OP_ENQUEUE, 32'hA5A5_5A5A, 1'b0, '0));
    directed_beats.push_back(make_beat(OP_ENQUEUE, 32'hFFFF_FFFF, 1'b0, '0));
    directed_beats.push_back(make_beat(OP_SEARCH, 32'hFFFF_FFFF, 1'b0, '0));
    directed_beats.push_back(make_beat(OP_DEQUEUE, 32'h0, 1'b1,
      make_result(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3, 0, 0, ST_OK)));
    directed_beats.push_back(make_beat(OP_CLEAR, 32'h0, 1'b1,
      make_result(0, 0, 0, 0, 0, 0, ST_OK)));
    // stale slots still hold this key but are no longer queued
    directed_beats.push_back(make_beat(OP_SEARCH, 32'hFFFF_FFFF, 1'b1,
      make_result(0, 0, 0, 0, 0, 0, ST_OK)));
    directed_beats.push_back(make_beat(OP_DEQUEUE, 32'h0, 1'b1,
      make_result(0, 0, 0, 0, 0, 0, ST_EMPTY_RD)));
    directed_beats.push_back(make_beat(OP_ENQUEUE, 32'h1234_5678, 1'b0, '0));
    // last entry leaves: front and rear must read zero, not the stale tail
    directed_beats.push_back(make_beat(OP_DEQUEUE, 32'h0, 1'b0, '0));
    directed_beats.push_back(make_beat(OP_ENQUEUE, 32'h8000_0001, 1'b0, '0));
    directed_beats.push_back(make_beat(OP_SEARCH, 32'h8000_0001, 1'b0, '0));

    foreach (directed_beats[i]) send_beat(directed_beats[i]);

    // Random: per phase, fill burst (reaches full and refused enqueues),
    // then mixed, then drain (reaches empty and refused dequeues).
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        mode = traffic_mode_t'((k / BURST_LEN) % 3);
        op   = pick_op(mode);
        val  = (op == OP_SEARCH) ? pick_key() : pick_value();
        send_beat(make_beat(op, val, 1'b0, '0));
      end
    end

    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    // catch any stray beat after the last expected one
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
